@@ design/hrd_pkg.sv @@
// Shared types, constants and character tables for the HTTP response dechunker.
package hrd_pkg;

  localparam int unsigned LINE_KEEP_DEF   = 50;
  localparam int unsigned LENGTH_BITS_DEF = 32;

  localparam int unsigned POS_BITS = 6;
  localparam logic [POS_BITS-1:0] POS_MAX    = 6'd63;
  localparam logic [POS_BITS-1:0] CODE_POS   = 6'd9;
  localparam logic [POS_BITS-1:0] STATUS_MIN = 6'd12;
  localparam logic [POS_BITS-1:0] LEN_LOC    = 6'd8;
  localparam logic [POS_BITS-1:0] LEN_CL     = 6'd14;
  localparam logic [POS_BITS-1:0] LEN_TE     = 6'd17;
  localparam logic [POS_BITS-1:0] LEN_PREFIX = 6'd7;
  localparam logic [POS_BITS-1:0] LEN_CHUNK  = 6'd8;

  // name_match bit positions
  localparam int unsigned M_LOC = 0;
  localparam int unsigned M_CL  = 1;
  localparam int unsigned M_TE  = 2;
  localparam logic [2:0] MATCH_ALL = 3'b111;

  localparam logic [9:0] CODE_NOT_FOUND = 10'd404;
  localparam logic [9:0] CODE_SERVER    = 10'd500;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;

  localparam logic [8*7-1:0]  STATUS_PREFIX = "HTTP/1.";
  localparam logic [8*8-1:0]  NAME_LOC      = "Location";
  localparam logic [8*14-1:0] NAME_CL       = "Content-Length";
  localparam logic [8*17-1:0] NAME_TE       = "Transfer-Encoding";
  localparam logic [8*8-1:0]  VALUE_CHUNKED = " chunked";

  typedef enum logic [3:0] {
    PH_STATUS      = 4'd0,
    PH_STATUS_LF   = 4'd1,
    PH_NAME        = 4'd2,
    PH_SKIP        = 4'd3,
    PH_CL_SPACE    = 4'd4,
    PH_CL_DIGITS   = 4'd5,
    PH_TE_VALUE    = 4'd6,
    PH_LINE_LF     = 4'd7,
    PH_HEAD_LF     = 4'd8,
    PH_BODY        = 4'd9,
    PH_CHUNK_VALUE = 4'd10,
    PH_CHUNK_TRAIL = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY      = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_NOT_FOUND = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } rx_item_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [7:0]  body_byte;
    logic [9:0]  response_code;
    logic        chunked;
    logic [31:0] content_length;
  } result_t;

  // Result handed from the parser to the output buffer
  typedef struct packed {
    logic    valid;
    result_t item;
  } push_t;

  // Character tables; callers only use an index below the string length.
  function automatic logic [7:0] status_char(input logic [2:0] i);
    return STATUS_PREFIX[8*(6-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] loc_char(input logic [2:0] i);
    return NAME_LOC[8*(7-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] i);
    return NAME_CL[8*(13-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    return NAME_TE[8*(16-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] chunked_char(input logic [2:0] i);
    return VALUE_CHUNKED[8*(7-int'(i)) +: 8];
  endfunction

endpackage

@@ design/hrd_stream_if.sv @@
// Valid/ready stream interface carrying one payload item.
interface hrd_stream_if #(
  parameter type payload_t = logic [7:0]
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (input clk, output valid, output data, input ready);
  modport sink   (input clk, input valid, input data, output ready);
endinterface

@@ design/hrd_parser.sv @@
// Per-byte response parser: state registers and next-state/result logic.
module hrd_parser #(
  parameter int unsigned LINE_KEEP   = hrd_pkg::LINE_KEEP_DEF,
  parameter int unsigned LENGTH_BITS = hrd_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  hrd_pkg::rx_item_t item,
  output hrd_pkg::push_t    push
);
  localparam int unsigned LB = LENGTH_BITS;

  hrd_pkg::phase_t                 phase, phase_next, s_phase;
  logic [hrd_pkg::POS_BITS-1:0]    line_position, pos_next, s_pos;
  logic [2:0]                      name_match, match_next, s_match;
  logic                            status_prefix_ok, prefix_next, s_prefix;
  logic [9:0]                      code_value, code_next, s_code;
  logic [LB-1:0]                   length_count, len_next, s_len;
  logic                            chunked_mode, chunked_next, s_chunked;

  logic [7:0]    c;
  logic          chunk_byte;
  logic          status_ok;
  logic [LB-1:0] len_dec10;
  logic [LB-1:0] len_hex;
  logic [13:0]   code_dec;

  assign c = item.rx_byte;

  // restart takes effect before the byte is looked at
  always_comb begin
    if (item.restart) begin
      s_phase   = hrd_pkg::PH_STATUS;
      s_pos     = '0;
      s_match   = hrd_pkg::MATCH_ALL;
      s_prefix  = 1'b1;
      s_code    = '0;
      s_len     = '0;
      s_chunked = 1'b0;
    end else begin
      s_phase   = phase;
      s_pos     = line_position;
      s_match   = name_match;
      s_prefix  = status_prefix_ok;
      s_code    = code_value;
      s_len     = length_count;
      s_chunked = chunked_mode;
    end
  end

  assign len_dec10 = (s_len << 3) + (s_len << 1) + LB'(c) - LB'(hrd_pkg::CH_ZERO);
  assign code_dec  = (14'(s_code) * 14'd10) + 14'(c - hrd_pkg::CH_ZERO);
  assign status_ok = s_prefix && (s_pos >= hrd_pkg::STATUS_MIN);

  always_comb begin
    len_hex = {s_len[LB-5:0], c[3:0]};
    if (c >= hrd_pkg::CH_A_LO) begin
      len_hex = {s_len[LB-5:0], 4'(c[3:0] + 4'd9)};
    end
  end

  always_comb begin
    phase_next   = s_phase;
    pos_next     = s_pos;
    match_next   = s_match;
    prefix_next  = s_prefix;
    code_next    = s_code;
    len_next     = s_len;
    chunked_next = s_chunked;
    chunk_byte   = 1'b0;
    push.valid   = 1'b0;
    push.item.out_kind      = hrd_pkg::KIND_BODY;
    push.item.body_byte     = '0;
    push.item.response_code = s_code;

    case (s_phase)
      hrd_pkg::PH_STATUS: begin
        if (c == hrd_pkg::CH_CR) begin
          phase_next = hrd_pkg::PH_STATUS_LF;
        end else if (s_pos < hrd_pkg::POS_BITS'(LINE_KEEP)) begin
          if (s_pos < hrd_pkg::LEN_PREFIX && c != hrd_pkg::status_char(s_pos[2:0])) begin
            prefix_next = 1'b0;
          end
          if (s_pos >= hrd_pkg::CODE_POS && s_pos < hrd_pkg::STATUS_MIN) begin
            if (c >= hrd_pkg::CH_ZERO && c <= hrd_pkg::CH_NINE) begin
              code_next = code_dec[9:0];
            end else begin
              prefix_next = 1'b0;
            end
          end
          pos_next = s_pos + 1'b1;
        end
      end
      hrd_pkg::PH_STATUS_LF: begin
        pos_next   = '0;
        match_next = hrd_pkg::MATCH_ALL;
        if (status_ok && s_code != hrd_pkg::CODE_NOT_FOUND && s_code < hrd_pkg::CODE_SERVER) begin
          phase_next = hrd_pkg::PH_NAME;
        end else begin
          phase_next  = hrd_pkg::PH_STATUS;
          prefix_next = 1'b1;
          code_next   = '0;
          push.valid  = 1'b1;
          if (status_ok && s_code == hrd_pkg::CODE_NOT_FOUND) begin
            push.item.out_kind      = hrd_pkg::KIND_NOT_FOUND;
            push.item.response_code = hrd_pkg::CODE_NOT_FOUND;
          end else begin
            push.item.out_kind      = hrd_pkg::KIND_ERROR;
            push.item.response_code = '0;
          end
        end
      end
      hrd_pkg::PH_NAME: begin
        if (c == hrd_pkg::CH_CR && s_pos == '0) begin
          phase_next = hrd_pkg::PH_HEAD_LF;
        end else if (c == hrd_pkg::CH_COLON) begin
          if (s_match[hrd_pkg::M_LOC] && s_pos >= hrd_pkg::LEN_LOC) begin
            phase_next = hrd_pkg::PH_SKIP;
          end else if (s_match[hrd_pkg::M_CL] && s_pos >= hrd_pkg::LEN_CL) begin
            len_next     = '0;
            chunked_next = 1'b0;
            phase_next   = hrd_pkg::PH_CL_SPACE;
          end else if (s_match[hrd_pkg::M_TE] && s_pos >= hrd_pkg::LEN_TE) begin
            match_next = 3'b001;
            pos_next   = '0;
            phase_next = hrd_pkg::PH_TE_VALUE;
          end else begin
            phase_next = hrd_pkg::PH_SKIP;
          end
        end else begin
          if (s_pos < hrd_pkg::LEN_LOC && c != hrd_pkg::loc_char(s_pos[2:0])) begin
            match_next[hrd_pkg::M_LOC] = 1'b0;
          end
          if (s_pos < hrd_pkg::LEN_CL && c != hrd_pkg::cl_char(s_pos[3:0])) begin
            match_next[hrd_pkg::M_CL] = 1'b0;
          end
          if (s_pos < hrd_pkg::LEN_TE && c != hrd_pkg::te_char(s_pos[4:0])) begin
            match_next[hrd_pkg::M_TE] = 1'b0;
          end
          if (s_pos < hrd_pkg::POS_MAX) begin
            pos_next = s_pos + 1'b1;
          end
        end
      end
      hrd_pkg::PH_SKIP: begin
        if (c == hrd_pkg::CH_CR) begin
          phase_next = hrd_pkg::PH_LINE_LF;
        end
      end
      hrd_pkg::PH_CL_SPACE: begin
        phase_next = hrd_pkg::PH_CL_DIGITS;
      end
      hrd_pkg::PH_CL_DIGITS: begin
        if (c == hrd_pkg::CH_CR) begin
          phase_next = hrd_pkg::PH_LINE_LF;
        end else begin
          len_next = len_dec10;
        end
      end
      hrd_pkg::PH_TE_VALUE: begin
        if (c == hrd_pkg::CH_CR) begin
          if (s_match[0] && s_pos >= hrd_pkg::LEN_CHUNK) begin
            chunked_next = 1'b1;
            len_next     = '0;
          end
          phase_next = hrd_pkg::PH_LINE_LF;
        end else begin
          if (s_pos < hrd_pkg::LEN_CHUNK && c != hrd_pkg::chunked_char(s_pos[2:0])) begin
            match_next[0] = 1'b0;
          end
          if (s_pos < hrd_pkg::POS_MAX) begin
            pos_next = s_pos + 1'b1;
          end
        end
      end
      hrd_pkg::PH_LINE_LF: begin
        pos_next   = '0;
        match_next = hrd_pkg::MATCH_ALL;
        phase_next = hrd_pkg::PH_NAME;
      end
      hrd_pkg::PH_HEAD_LF: begin
        if (s_chunked) begin
          len_next   = '0;
          phase_next = hrd_pkg::PH_CHUNK_VALUE;
        end else begin
          phase_next = hrd_pkg::PH_BODY;
        end
        push.valid         = 1'b1;
        push.item.out_kind = hrd_pkg::KIND_HEADER;
      end
      hrd_pkg::PH_BODY: begin
        if (!s_chunked) begin
          push.valid          = 1'b1;
          push.item.body_byte = c;
        end else if (s_len != '0) begin
          len_next            = s_len - 1'b1;
          push.valid          = 1'b1;
          push.item.body_byte = c;
        end else begin
          phase_next = hrd_pkg::PH_CHUNK_VALUE;
          chunk_byte = 1'b1;
        end
      end
      hrd_pkg::PH_CHUNK_VALUE: begin
        chunk_byte = 1'b1;
      end
      hrd_pkg::PH_CHUNK_TRAIL: begin
        if (c == hrd_pkg::CH_LF) begin
          phase_next = hrd_pkg::PH_BODY;
        end
      end
      default: begin
        phase_next   = hrd_pkg::PH_STATUS;
        pos_next     = '0;
        match_next   = hrd_pkg::MATCH_ALL;
        prefix_next  = 1'b1;
        code_next    = '0;
        len_next     = '0;
        chunked_next = 1'b0;
      end
    endcase

    // chunk size line: hex digits shift in until CR or ';'
    if (chunk_byte) begin
      case (c) inside
        hrd_pkg::CH_CR, hrd_pkg::CH_SEMI: phase_next = hrd_pkg::PH_CHUNK_TRAIL;
        [hrd_pkg::CH_ZERO:hrd_pkg::CH_NINE], [hrd_pkg::CH_A_LO:hrd_pkg::CH_F_LO]:
          len_next = len_hex;
        default: ;
      endcase
    end

    push.item.chunked        = chunked_next;
    push.item.content_length = 32'(len_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= hrd_pkg::PH_STATUS;
      line_position    <= '0;
      name_match       <= hrd_pkg::MATCH_ALL;
      status_prefix_ok <= 1'b1;
      code_value       <= '0;
      length_count     <= '0;
      chunked_mode     <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      line_position    <= pos_next;
      name_match       <= match_next;
      status_prefix_ok <= prefix_next;
      code_value       <= code_next;
      length_count     <= len_next;
      chunked_mode     <= chunked_next;
    end
  end

  // a status failure always sends the parser back to the status line
  a_fail_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && push.valid && (push.item.out_kind == hrd_pkg::KIND_ERROR ||
      push.item.out_kind == hrd_pkg::KIND_NOT_FOUND)
    |=> phase == hrd_pkg::PH_STATUS && code_value == '0)
    else $error("status failure did not return to status line");

  // every chunked body byte consumes one count
  a_chunk_count: assert property (@(posedge clk) disable iff (rst)
    accept && push.valid && push.item.out_kind == hrd_pkg::KIND_BODY && push.item.chunked
    |=> length_count == $past(length_count) - 1'b1)
    else $error("chunked body byte without count decrement");

endmodule

@@ design/hrd_out_buf.sv @@
// Two-entry result buffer between the parser and the result channel.
module hrd_out_buf (
  input  logic                     clk,
  input  logic                     rst,
  input  hrd_pkg::push_t           push,
  output logic                     room,
  hrd_stream_if.source             result
);
  hrd_pkg::result_t slot0, slot0_next;
  hrd_pkg::result_t slot1, slot1_next;
  logic [1:0]       count, count_next;
  logic             pop;
  logic             wr_idx;

  assign room         = (count != 2'd2);
  assign result.valid = (count != 2'd0);
  assign result.data  = slot0;
  assign pop          = result.valid && result.ready;
  assign wr_idx       = 1'(count - 2'(pop));

  always_comb begin
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    if (push.valid) begin
      if (wr_idx) begin
        slot1_next = push.item;
      end else begin
        slot0_next = push.item;
      end
    end
    count_next = count + 2'(push.valid) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> count != 2'd2)
    else $error("result pushed into full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("buffer count out of range");

endmodule

@@ design/http_response_dechunker.sv @@
// Top level: HTTP response header parser and chunked body decoder.
//
//  channel  dir  payload                                            accepted when
//  rx       in   rx_byte[8], restart[1]                             rx.valid & rx.ready
//  result   out  out_kind[2], body_byte[8], response_code[10],
//                chunked[1], content_length[32]                     result.valid & result.ready
//
// One byte is accepted per cycle; each byte is decoded by the per-state logic in
// hrd_parser in the cycle it is accepted, and its result (if any) is written into a
// two-entry buffer that presents the oldest result on the result channel.
// rx.ready drops only while both buffer entries hold results that have not been taken.
// rst is synchronous and returns the parser to the status-line state and empties
// the buffer; restart on an item does the same for the parser alone.
module http_response_dechunker #(
  parameter int unsigned LINE_KEEP   = hrd_pkg::LINE_KEEP_DEF,   // status chars counted
  parameter int unsigned LENGTH_BITS = hrd_pkg::LENGTH_BITS_DEF  // length register width
) (
  input logic          clk,
  input logic          rst,
  hrd_stream_if.sink   rx,
  hrd_stream_if.source result
);
  hrd_pkg::push_t push;
  logic           room;
  logic           accept;

  // the parser only advances on an accepted item; results go straight to the buffer
  assign rx.ready = room;
  assign accept   = rx.valid && room;

  hrd_parser #(
    .LINE_KEEP   (LINE_KEEP),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (rx.data),
    .push   (push)
  );

  // results are pushed only for accepted items
  hrd_pkg::push_t push_q;
  always_comb begin
    push_q       = push;
    push_q.valid = push.valid && accept;
  end

  hrd_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .push   (push_q),
    .room   (room),
    .result (result)
  );

endmodule

@@ dv/http_response_dechunker_tb.sv @@
// Self-checking testbench for the HTTP response dechunker: random responses, scoreboard check.

// Scoreboard: mirrors the parser state byte by byte and holds the results still owed.
class dechunk_scoreboard;
  hrd_pkg::phase_t  stage;
  logic [5:0]       pos;
  logic [2:0]       name_hits;
  logic             prefix_ok;
  logic [9:0]       code_val;
  logic [31:0]      len_count;
  logic             chunk_mode;
  hrd_pkg::result_t pending_results[$];
  int               failures = 0;
  int               reported = 0;
  int               checked = 0;
  int               kind_seen[4] = '{0, 0, 0, 0};
  string            status_txt = "HTTP/1.";
  string            loc_txt = "Location";
  string            cl_txt = "Content-Length";
  string            te_txt = "Transfer-Encoding";
  string            chunk_txt = " chunked";

  function new();
    restart_parser();
  endfunction

  function void restart_parser();
    stage = hrd_pkg::PH_STATUS;
    pos = '0;
    name_hits = hrd_pkg::MATCH_ALL;
    prefix_ok = 1'b1;
    code_val = '0;
    len_count = '0;
    chunk_mode = 1'b0;
  endfunction

  function void queue_result(hrd_pkg::kind_t k, logic [7:0] b, logic [9:0] cd);
    hrd_pkg::result_t r;
    r.out_kind = k;
    r.body_byte = b;
    r.response_code = cd;
    r.chunked = chunk_mode;
    r.content_length = len_count;
    pending_results.push_back(r);
  endfunction

  // One byte of a chunk-size line: hex digits shift in, CR or ';' ends the number.
  function void take_size_char(logic [7:0] c);
    logic [7:0] d;
    if (c == hrd_pkg::CH_CR || c == hrd_pkg::CH_SEMI) begin
      stage = hrd_pkg::PH_CHUNK_TRAIL;
    end else if (c >= hrd_pkg::CH_ZERO && c <= hrd_pkg::CH_NINE) begin
      d = c - hrd_pkg::CH_ZERO;
      len_count = {len_count[27:0], d[3:0]};
    end else if (c >= hrd_pkg::CH_A_LO && c <= hrd_pkg::CH_F_LO) begin
      d = c - hrd_pkg::CH_A_LO + 8'd10;
      len_count = {len_count[27:0], d[3:0]};
    end
  endfunction

  // Advance the mirrored parser by one accepted byte, queueing any result it owes.
  function void parse_byte(hrd_pkg::rx_item_t it);
    logic [7:0] c;
    logic [5:0] p;
    logic       ok;
    logic [9:0] cd;
    c = it.rx_byte;
    if (it.restart) restart_parser();
    p = pos;
    case (stage)
      hrd_pkg::PH_STATUS: begin
        if (c == hrd_pkg::CH_CR) begin
          stage = hrd_pkg::PH_STATUS_LF;
        end else if (p < hrd_pkg::LINE_KEEP_DEF) begin
          if (p < hrd_pkg::LEN_PREFIX && c != status_txt[p]) prefix_ok = 1'b0;
          if (p >= hrd_pkg::CODE_POS && p < hrd_pkg::STATUS_MIN) begin
            if (c >= hrd_pkg::CH_ZERO && c <= hrd_pkg::CH_NINE)
              code_val = code_val * 10'd10 + (c - hrd_pkg::CH_ZERO);
            else prefix_ok = 1'b0;
          end
          pos = p + 6'd1;
        end
      end
      hrd_pkg::PH_STATUS_LF: begin
        ok = prefix_ok && p >= hrd_pkg::STATUS_MIN;
        cd = code_val;
        pos = '0;
        name_hits = hrd_pkg::MATCH_ALL;
        if (ok && cd != hrd_pkg::CODE_NOT_FOUND && cd < hrd_pkg::CODE_SERVER) begin
          stage = hrd_pkg::PH_NAME;
        end else begin
          stage = hrd_pkg::PH_STATUS;
          prefix_ok = 1'b1;
          code_val = '0;
          if (ok && cd == hrd_pkg::CODE_NOT_FOUND)
            queue_result(hrd_pkg::KIND_NOT_FOUND, 8'd0, hrd_pkg::CODE_NOT_FOUND);
          else queue_result(hrd_pkg::KIND_ERROR, 8'd0, 10'd0);
        end
      end
      hrd_pkg::PH_NAME: begin
        if (c == hrd_pkg::CH_CR && p == 0) begin
          stage = hrd_pkg::PH_HEAD_LF;
        end else if (c == hrd_pkg::CH_COLON) begin
          if (name_hits[hrd_pkg::M_LOC] && p >= hrd_pkg::LEN_LOC) begin
            stage = hrd_pkg::PH_SKIP;
          end else if (name_hits[hrd_pkg::M_CL] && p >= hrd_pkg::LEN_CL) begin
            len_count = '0;
            chunk_mode = 1'b0;
            stage = hrd_pkg::PH_CL_SPACE;
          end else if (name_hits[hrd_pkg::M_TE] && p >= hrd_pkg::LEN_TE) begin
            name_hits = 3'b001;
            pos = '0;
            stage = hrd_pkg::PH_TE_VALUE;
          end else begin
            stage = hrd_pkg::PH_SKIP;
          end
        end else begin
          if (p < hrd_pkg::LEN_LOC && c != loc_txt[p]) name_hits[hrd_pkg::M_LOC] = 1'b0;
          if (p < hrd_pkg::LEN_CL && c != cl_txt[p]) name_hits[hrd_pkg::M_CL] = 1'b0;
          if (p < hrd_pkg::LEN_TE && c != te_txt[p]) name_hits[hrd_pkg::M_TE] = 1'b0;
          if (p < hrd_pkg::POS_MAX) pos = p + 6'd1;
        end
      end
      hrd_pkg::PH_SKIP: if (c == hrd_pkg::CH_CR) stage = hrd_pkg::PH_LINE_LF;
      hrd_pkg::PH_CL_SPACE: stage = hrd_pkg::PH_CL_DIGITS;
      hrd_pkg::PH_CL_DIGITS: begin
        if (c == hrd_pkg::CH_CR) stage = hrd_pkg::PH_LINE_LF;
        else len_count = len_count * 32'd10 + {24'd0, c} - 32'd48;
      end
      hrd_pkg::PH_TE_VALUE: begin
        if (c == hrd_pkg::CH_CR) begin
          if (name_hits[hrd_pkg::M_LOC] && p >= hrd_pkg::LEN_CHUNK) begin
            chunk_mode = 1'b1;
            len_count = '0;
          end
          stage = hrd_pkg::PH_LINE_LF;
        end else begin
          if (p < hrd_pkg::LEN_CHUNK && c != chunk_txt[p]) name_hits[hrd_pkg::M_LOC] = 1'b0;
          if (p < hrd_pkg::POS_MAX) pos = p + 6'd1;
        end
      end
      hrd_pkg::PH_LINE_LF: begin
        pos = '0;
        name_hits = hrd_pkg::MATCH_ALL;
        stage = hrd_pkg::PH_NAME;
      end
      hrd_pkg::PH_HEAD_LF: begin
        if (chunk_mode) begin
          len_count = '0;
          stage = hrd_pkg::PH_CHUNK_VALUE;
        end else begin
          stage = hrd_pkg::PH_BODY;
        end
        queue_result(hrd_pkg::KIND_HEADER, 8'd0, code_val);
      end
      hrd_pkg::PH_BODY: begin
        if (!chunk_mode) begin
          queue_result(hrd_pkg::KIND_BODY, c, code_val);
        end else if (len_count != 0) begin
          len_count = len_count - 32'd1;
          queue_result(hrd_pkg::KIND_BODY, c, code_val);
        end else begin
          stage = hrd_pkg::PH_CHUNK_VALUE;
          take_size_char(c);
        end
      end
      hrd_pkg::PH_CHUNK_VALUE: take_size_char(c);
      hrd_pkg::PH_CHUNK_TRAIL: if (c == hrd_pkg::CH_LF) stage = hrd_pkg::PH_BODY;
      default: restart_parser();
    endcase
  endfunction

  function string show(hrd_pkg::result_t r);
    return $sformatf("kind=%0d byte=%02h code=%0d chunked=%0b len=%0d",
                     r.out_kind, r.body_byte, r.response_code, r.chunked, r.content_length);
  endfunction

  function void check_result(hrd_pkg::result_t got);
    hrd_pkg::result_t want;
    if (pending_results.size() == 0) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("%0t: result with nothing outstanding: %s", $time, show(got));
      end
      return;
    end
    want = pending_results.pop_front();
    checked++;
    kind_seen[int'(got.out_kind)]++;
    if (got.out_kind !== want.out_kind || got.body_byte !== want.body_byte ||
        got.response_code !== want.response_code || got.chunked !== want.chunked ||
        got.content_length !== want.content_length) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("%0t: mismatch\n  expected %s\n  actual   %s", $time, show(want), show(got));
      end
    end
  endfunction

  function void finish_check();
    if (pending_results.size() != 0) begin
      failures += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
  endfunction
endclass

module http_response_dechunker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 4000;  // cycles with no handshake on either side
  localparam int SETTLE_CYCLES = 20;    // quiet time after the last expected result
  localparam int BYTE_TARGET   = 1950;

  logic clk;
  logic rst;

  hrd_stream_if #(.payload_t(hrd_pkg::rx_item_t)) rx_if (clk);
  hrd_stream_if #(.payload_t(hrd_pkg::result_t))  res_if (clk);

  http_response_dechunker dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .result(res_if)
  );

  dechunk_scoreboard board = new();

  bit calm;           // when set, neither side idles
  bit finished;
  bit force_restart;  // next response must begin with restart
  bit mid_hold;
  int bytes_sent;
  int responses;
  int stall_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic string rand_word(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++)
      s = {s, $sformatf("%c", $urandom_range(0, 1) ? $urandom_range(97, 122)
                                                    : $urandom_range(65, 90))};
    return s;
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  // Result side: ready drops for random stretches; checking happens at the rising edge.
  always @(negedge clk) begin
    int gap;
    if (calm) begin
      stall_left = 0;
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      gap = pick_gap();
      stall_left = (gap > 0) ? gap - 1 : 0;
      res_if.ready <= (gap == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) board.check_result(res_if.data);
  end

  // Watchdog: a stuck handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || finished || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one byte after a random gap; the item counts once valid and ready meet.
  task automatic push_byte(logic [7:0] b, bit rs);
    hrd_pkg::rx_item_t it;
    int gap;
    it.rx_byte = b;
    it.restart = rs;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      rx_if.valid <= 1'b0;
    end
    @(negedge clk);
    rx_if.valid <= 1'b1;
    rx_if.data <= it;
    do @(posedge clk); while (!rx_if.ready);
    board.parse_byte(it);
    bytes_sent++;
  endtask

  // A text line, its CR, and the byte after it (usually LF, sometimes junk).
  task automatic send_line(string s, bit rs);
    logic [7:0] tail;
    for (int i = 0; i < s.len(); i++) push_byte(s[i], rs && i == 0);
    push_byte(hrd_pkg::CH_CR, rs && s.len() == 0);
    tail = hrd_pkg::CH_LF;
    if ($urandom_range(0, 19) == 0) tail = $urandom_range(0, 255);
    push_byte(tail, 1'b0);
  endtask

  // Sender stops until every outstanding result has been taken.
  task automatic hold_until_drained();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // One response: status line and, when the parser accepts it, headers, blank line
  // and a body in whatever mode the headers selected. Bad status lines, odd header names
  // and framing noise are mixed in so that every parser branch gets traffic.
  task automatic send_response();
    string      line;
    string      junk;
    int         sel;
    int         code;
    int         n;
    int         size;
    logic [7:0] b;
    bit         rs;
    rs = force_restart || ($urandom_range(0, 9) != 0);
    force_restart = 1'b0;
    calm = ($urandom_range(0, 6) == 0);
    responses++;

    // status line
    sel = $urandom_range(0, 99);
    code = $urandom_range(100, 499);
    if (code == 404) code = 200;
    if (sel >= 55 && sel < 63) code = 404;
    else if (sel >= 63 && sel < 71) code = $urandom_range(500, 999);
    line = $sformatf("HTTP/1.%0d %0d %s", $urandom_range(0, 9), code,
                     rand_word($urandom_range(0, 8)));
    if (sel >= 71 && sel < 77) begin
      // one prefix character wrong
      n = $urandom_range(0, 6);
      b = $urandom_range(1, 255);
      if (b == line[n] || b == hrd_pkg::CH_CR) b = line[n] ^ 8'h20;
      line[n] = b;
    end else if (sel >= 77 && sel < 83) begin
      // too short to hold a code
      n = $urandom_range(0, 11);
      line = (n == 0) ? "" : line.substr(0, n - 1);
    end else if (sel >= 83 && sel < 89) begin
      junk = "x-/:A ";
      line[9 + $urandom_range(0, 2)] = junk[$urandom_range(0, 5)];
    end else if (sel >= 89 && sel < 95) begin
      // long reason phrase runs past the kept part of the line
      line = {line, " ", rand_word($urandom_range(40, 70))};
    end else if (sel >= 95) begin
      line = "";
      repeat ($urandom_range(0, 15)) begin
        b = $urandom_range(1, 255);
        if (b == hrd_pkg::CH_CR) b = 8'h0e;
        line = {line, $sformatf("%c", b)};
      end
    end
    send_line(line, rs);
    if (board.stage != hrd_pkg::PH_NAME) return;

    // header lines
    repeat ($urandom_range(0, 3)) begin
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        case ($urandom_range(0, 9))
          0: line = rand_digits(12);
          1: line = "1x9";
          2: line = "";
          3: line = $sformatf("%0d", $urandom);
          default: line = $sformatf("%0d", $urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 19))
          0: junk = "Content-Lengthy";
          1: junk = "content-length";
          2: junk = "Content-Len";
          default: junk = "Content-Length";
        endcase
        // without the space the first digit is the one that gets skipped
        if ($urandom_range(0, 7) == 0) line = {junk, ":", line};
        else line = {junk, ": ", line};
      end else if (sel < 50) begin
        case ($urandom_range(0, 7))
          0: line = " chunked, gzip";
          1: line = " gzip";
          2: line = "chunked";
          3: line = " chunk";
          4: line = " Chunked";
          default: line = " chunked";
        endcase
        case ($urandom_range(0, 9))
          0: junk = "Transfer-Encodings";
          1: junk = "Transfer-Enc";
          default: junk = "Transfer-Encoding";
        endcase
        line = {junk, ":", line};
      end else if (sel < 58) begin
        line = {"Location: /", rand_word($urandom_range(0, 6))};
      end else if (sel < 66) begin
        line = $sformatf("Con%ctent-Length: %0d", hrd_pkg::CH_CR, $urandom_range(0, 99));
      end else if (sel < 74) begin
        line = {rand_word($urandom_range(60, 70)), ": x"};
      end else if (sel < 80) begin
        case ($urandom_range(0, 2))
          0: line = "Content: 5";
          1: line = "Transfer-Enc: chunked";
          default: line = "Loc: /";
        endcase
      end else if (sel < 83) begin
        // no colon: the CR/LF become part of the name
        line = rand_word($urandom_range(4, 10));
      end else begin
        line = {rand_word($urandom_range(1, 10)), ": ", rand_word($urandom_range(0, 10))};
      end
      send_line(line, 1'b0);
    end
    send_line("", 1'b0);

    if (board.stage == hrd_pkg::PH_BODY) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 20);
      repeat (n) push_byte($urandom_range(0, 255), $urandom_range(0, 99) == 0);
    end else if (board.stage == hrd_pkg::PH_CHUNK_VALUE) begin
      repeat ($urandom_range(1, 3)) begin
        size = $urandom_range(1, 40);
        line = $sformatf("%0h", size);
        case ($urandom_range(0, 9))
          0: line = {"0", line};
          1: line = {"x", line, "Z"};
          2: line = {line, ";ext=", rand_word(3)};
          3: begin
            // size far beyond the run; the next response restarts the parser
            send_line("fffffffff", 1'b0);
            force_restart = 1'b1;
            return;
          end
          default: ;
        endcase
        send_line(line, 1'b0);
        repeat (size) push_byte($urandom_range(0, 255), 1'b0);
        send_line("", 1'b0);
      end
      send_line("0", 1'b0);
      send_line("", 1'b0);
    end else begin
      repeat ($urandom_range(0, 6)) push_byte($urandom_range(0, 255), 1'b0);
    end
  endtask

  initial begin
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.data = '0;
    res_if.ready = 1'b0;
    calm = 1'b0;
    finished = 1'b0;
    force_restart = 1'b0;
    mid_hold = 1'b0;
    bytes_sent = 0;
    responses = 0;
    stall_left = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: all-ones/all-zeros bytes with restart, a garbage status line
    // that must give an error, then a clean not-found.
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(hrd_pkg::CH_CR, 1'b0);
    push_byte(8'hff, 1'b0);
    send_line("HTTP/1.1 404", 1'b1);
    hold_until_drained();

    while (bytes_sent < BYTE_TARGET) begin
      if (!mid_hold && bytes_sent >= BYTE_TARGET / 2) begin
        mid_hold = 1'b1;
        hold_until_drained();
      end
      send_response();
    end
    @(negedge clk);
    rx_if.valid <= 1'b0;

    // Drain, then make sure nothing extra shows up.
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    finished = 1'b1;
    board.finish_check();

    $display("sent %0d bytes in %0d responses; checked %0d results", bytes_sent, responses,
             board.checked);
    $display("  %0d body bytes, %0d header-done, %0d not-found, %0d error; %0d failures",
             board.kind_seen[0], board.kind_seen[1], board.kind_seen[2], board.kind_seen[3],
             board.failures);
    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
